@@ hw/rtl/tkvc_pkg.sv @@
// shared types and constants of the top-k visit count selector
package tkvc_pkg;

  localparam int unsigned TOP_K_DEF = 5;
  localparam int unsigned MOVE_W    = 16;
  localparam int unsigned VISITS_W  = 31;
  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned PRIOR_W   = 16;
  localparam int unsigned RANK_W    = 3;

  typedef struct packed {
    logic [MOVE_W-1:0]          move;
    logic [VISITS_W-1:0]        visits;
    logic signed [VALUE_W-1:0]  value;
    logic [PRIOR_W-1:0]         prior;
  } rec_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_SHIFT
  } cell_op_t;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } state_t;

endpackage

@@ hw/rtl/tkvc_if.sv @@
// request and result channel interfaces of the top-k visit count selector
interface tkvc_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [tkvc_pkg::MOVE_W-1:0]            move_code;
  logic [tkvc_pkg::VISITS_W-1:0]          visit_count;
  logic signed [tkvc_pkg::VALUE_W-1:0]    mean_value;
  logic [tkvc_pkg::PRIOR_W-1:0]           prior;
  logic                                   last_child;

  modport source (output valid, move_code, visit_count, mean_value, prior, last_child,
                  input ready);
  modport sink (input valid, move_code, visit_count, mean_value, prior, last_child,
                output ready);
endinterface

interface tkvc_out_if;
  logic                                   valid;
  logic                                   ready;
  logic [tkvc_pkg::RANK_W-1:0]            rank;
  logic [tkvc_pkg::MOVE_W-1:0]            out_move;
  logic [tkvc_pkg::VISITS_W-1:0]          out_visits;
  logic signed [tkvc_pkg::VALUE_W-1:0]    out_value;
  logic [tkvc_pkg::PRIOR_W-1:0]           out_prior;
  logic                                   last_of_run;

  modport source (output valid, rank, out_move, out_visits, out_value, out_prior, last_of_run,
                  input ready);
  modport sink (input valid, rank, out_move, out_visits, out_value, out_prior, last_of_run,
                output ready);
endinterface

@@ hw/rtl/tkvc_cell.sv @@
// one slot of the sorted list: compare, insert, shift towards the head
module tkvc_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  tkvc_pkg::cell_op_t op,
  input  tkvc_pkg::rec_t     new_rec,
  input  tkvc_pkg::rec_t     prev_rec,
  input  logic               prev_valid,
  input  logic               prev_ins,
  input  tkvc_pkg::rec_t     next_rec,
  input  logic               next_valid,
  output tkvc_pkg::rec_t     rec,
  output logic               valid,
  output logic               ins
);

  tkvc_pkg::rec_t rec_r, rec_nxt;
  logic           valid_r, valid_nxt;

  // new record goes ahead of an empty slot or a strictly smaller count
  assign ins = !valid_r || (rec_r.visits < new_rec.visits);

  always_comb begin
    rec_nxt   = rec_r;
    valid_nxt = valid_r;
    case (op)
      tkvc_pkg::OP_INSERT: begin
        if (ins) begin
          if (prev_ins) begin
            rec_nxt   = prev_rec;
            valid_nxt = prev_valid;
          end else begin
            rec_nxt   = new_rec;
            valid_nxt = 1'b1;
          end
        end
      end
      tkvc_pkg::OP_SHIFT: begin
        rec_nxt   = next_rec;
        valid_nxt = next_valid;
      end
      default: begin
        rec_nxt   = rec_r;
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign rec   = rec_r;
  assign valid = valid_r;

endmodule

@@ hw/rtl/top_k_by_visit_count.sv @@
// top level of the top-k visit count selector
// Keeps the TOP_K candidates with the largest visit counts in a chain of TOP_K compare cells,
// sorted in descending order, equal counts in arrival order. A request that is not marked
// last_child is taken one per cycle outside the drain, whatever the result side is doing. A
// request marked last_child is taken the same way and is followed by a drain of N results
// (N = filled slots, 1 to TOP_K), one per cycle while out_chan.ready is high; the head cell
// feeds the output register and the chain shifts up by one slot on each load, so the list is
// empty when the final result has been loaded. No request is taken during the drain. There
// is no clearing pass after reset.
module top_k_by_visit_count #(
  parameter int unsigned TOP_K = tkvc_pkg::TOP_K_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  tkvc_in_if.sink         in_chan,
  tkvc_out_if.source      out_chan
);

  localparam int unsigned CNT_W = (TOP_K > 1) ? $clog2(TOP_K) : 1;

  tkvc_pkg::state_t   state_r, state_nxt;
  tkvc_pkg::cell_op_t op;
  tkvc_pkg::rec_t     new_rec;
  logic               in_acc;
  logic               load;
  logic               drain_last;

  tkvc_pkg::rec_t     cell_rec  [TOP_K];
  logic               cell_valid[TOP_K];
  logic               cell_ins  [TOP_K];
  tkvc_pkg::rec_t     prev_rec  [TOP_K];
  logic               prev_valid[TOP_K];
  logic               prev_ins  [TOP_K];
  tkvc_pkg::rec_t     next_rec  [TOP_K];
  logic               next_valid[TOP_K];

  logic [CNT_W-1:0]   rank_cnt_r, rank_cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  tkvc_pkg::rec_t     out_rec_r;
  logic [tkvc_pkg::RANK_W-1:0] out_rank_r;
  logic               out_last_r;

  assign new_rec.move   = in_chan.move_code;
  assign new_rec.visits = in_chan.visit_count;
  assign new_rec.value  = in_chan.mean_value;
  assign new_rec.prior  = in_chan.prior;

  // neighbour wiring of the chain
  generate
    for (genvar i = 0; i < TOP_K; i++) begin : g_cell
      if (i == 0) begin : g_head
        assign prev_rec[i]   = new_rec;
        assign prev_valid[i] = 1'b1;
        assign prev_ins[i]   = 1'b0;
      end else begin : g_body
        assign prev_rec[i]   = cell_rec[i-1];
        assign prev_valid[i] = cell_valid[i-1];
        assign prev_ins[i]   = cell_ins[i-1];
      end
      if (i == TOP_K - 1) begin : g_tail
        assign next_rec[i]   = cell_rec[i];
        assign next_valid[i] = 1'b0;
      end else begin : g_inner
        assign next_rec[i]   = cell_rec[i+1];
        assign next_valid[i] = cell_valid[i+1];
      end

      tkvc_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .new_rec    (new_rec),
        .prev_rec   (prev_rec[i]),
        .prev_valid (prev_valid[i]),
        .prev_ins   (prev_ins[i]),
        .next_rec   (next_rec[i]),
        .next_valid (next_valid[i]),
        .rec        (cell_rec[i]),
        .valid      (cell_valid[i]),
        .ins        (cell_ins[i])
      );
    end
  endgenerate

  // the entry behind the head is empty: this is the final result
  assign drain_last = !next_valid[0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tkvc_pkg::ST_FILL: begin
        if (in_acc && in_chan.last_child) begin
          state_nxt = tkvc_pkg::ST_DRAIN;
        end
      end
      tkvc_pkg::ST_DRAIN: begin
        if (load && drain_last) begin
          state_nxt = tkvc_pkg::ST_FILL;
        end
      end
      default: begin
        state_nxt = tkvc_pkg::ST_FILL;
      end
    endcase
  end

  always_comb begin
    in_chan.ready = 1'b0;
    load          = 1'b0;
    op            = tkvc_pkg::OP_HOLD;
    case (state_r)
      tkvc_pkg::ST_FILL: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          op = tkvc_pkg::OP_INSERT;
        end
      end
      tkvc_pkg::ST_DRAIN: begin
        load = !out_valid_r || out_chan.ready;
        if (load) begin
          op = tkvc_pkg::OP_SHIFT;
        end
      end
      default: begin
        op = tkvc_pkg::OP_HOLD;
      end
    endcase
  end

  assign in_acc = in_chan.valid && in_chan.ready;

  always_comb begin
    rank_cnt_nxt = rank_cnt_r;
    if (load) begin
      rank_cnt_nxt = drain_last ? '0 : rank_cnt_r + 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tkvc_pkg::ST_FILL;
      rank_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rank_cnt_r  <= rank_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_rec_r  <= cell_rec[0];
      out_rank_r <= tkvc_pkg::RANK_W'(rank_cnt_r);
      out_last_r <= drain_last;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.rank        = out_rank_r;
  assign out_chan.out_move    = out_rec_r.move;
  assign out_chan.out_visits  = out_rec_r.visits;
  assign out_chan.out_value   = out_rec_r.value;
  assign out_chan.out_prior   = out_rec_r.prior;
  assign out_chan.last_of_run = out_last_r;

endmodule

@@ hw/rtl/tkvc_checker.sv @@
// port-level checks of the top-k visit count selector and their bind
module tkvc_checker #(
  parameter int unsigned TOP_K = tkvc_pkg::TOP_K_DEF
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [tkvc_pkg::RANK_W-1:0]         rank,
  input logic [tkvc_pkg::MOVE_W-1:0]         out_move,
  input logic [tkvc_pkg::VISITS_W-1:0]       out_visits,
  input logic signed [tkvc_pkg::VALUE_W-1:0] out_value,
  input logic [tkvc_pkg::PRIOR_W-1:0]        out_prior,
  input logic                                last_of_run
);

  logic                              out_acc;
  logic [tkvc_pkg::RANK_W-1:0]       exp_rank_r, exp_rank_nxt;
  logic [tkvc_pkg::VISITS_W-1:0]     prev_visits_r;

  assign out_acc = out_valid && out_ready;

  always_comb begin
    exp_rank_nxt = exp_rank_r;
    if (out_acc) begin
      exp_rank_nxt = last_of_run ? '0 : exp_rank_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_rank_r <= '0;
    end else begin
      exp_rank_r <= exp_rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) begin
      prev_visits_r <= out_visits;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(rank) && $stable(out_move) &&
      $stable(out_visits) && $stable(out_value) && $stable(out_prior) && $stable(last_of_run))
    else $error("result changed while stalled");

  // ranks count up from zero within a run
  a_rank_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> rank == exp_rank_r)
    else $error("rank out of sequence");

  // visit counts never rise within a run
  a_descending: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && rank != '0 |-> out_visits <= prev_visits_r)
    else $error("visit counts not descending");

  // a run is never longer than the list
  a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(rank) < TOP_K) && (32'(rank) != TOP_K - 1 || last_of_run))
    else $error("run longer than the list");

endmodule

bind top_k_by_visit_count tkvc_checker #(
  .TOP_K (TOP_K)
) u_tkvc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .rank        (out_chan.rank),
  .out_move    (out_chan.out_move),
  .out_visits  (out_chan.out_visits),
  .out_value   (out_chan.out_value),
  .out_prior   (out_chan.out_prior),
  .last_of_run (out_chan.last_of_run)
);
